@@ rtl/mecanum_wheel_mixer_unit_macros.svh @@
// Assertion macros shared by the mecanum wheel mixer RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef MECANUM_WHEEL_MIXER_UNIT_MACROS_SVH
`define MECANUM_WHEEL_MIXER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define MWM_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define MWM_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MWM_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define MWM_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

@@ rtl/mwm_pkg.sv @@
// Package for the mecanum wheel mixer: field widths, step counts and the
// sequencer state type. No dependencies.
`default_nettype none

package mwm_pkg;

    localparam int AXIS_W     = 16;   // Q1.15 stick axis
    localparam int HUND_W     = 8;    // signed hundredths, -100..100
    localparam int WHEEL_W    = 10;   // signed wheel sum, -300..300
    localparam int MAG_W      = 9;    // wheel magnitude and divisor, 0..300
    localparam int QUOT_W     = 17;   // Q.16 fraction magnitude, 0..65536
    localparam int CMD_W      = 27;   // signed wheel command
    localparam int MAXOUT_W   = 10;
    localparam int PRESS_W    = 4;
    localparam int NUM_WHEELS = 4;
    localparam int NUM_AXES   = 3;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 112;
    localparam int OUT_TUSER_W = 1;

    localparam int SQ_STEPS  = 16;    // one multiplier bit per step
    localparam int DIV_STEPS = 17;    // one quotient bit per step
    localparam int SCL_STEPS = 10;    // one max_output bit per step

    localparam logic [MAG_W-1:0]    HUNDRED      = 9'd100;
    localparam logic [MAXOUT_W-1:0] MAXOUT_RESET = 10'd500;
    localparam logic [MAXOUT_W-1:0] UNIT_SCALE   = 10'd1;

    // Wheels 1 and 3 sit on the right side and are driven negated.
    localparam logic [NUM_WHEELS-1:0] RIGHT_WHEELS = 4'b1010;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_MIX,
        ST_DIVIDE,
        ST_SCALE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ rtl/mwm_square.sv @@
// Bit-serial signed squarer: stick axis to truncated hundredths.
// Depends on mwm_pkg.
`default_nettype none

module mwm_square
    import mwm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [AXIS_W-1:0] axis,
    output logic                          done,
    output logic signed [HUND_W-1:0]      hundredths
);

    localparam int A_W   = AXIS_W + 6;    // magnitude times 100
    localparam int S_W   = A_W + 1;
    localparam int CNT_W = $clog2(SQ_STEPS);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [A_W-1:0]     a_reg, a_next;
    logic [AXIS_W-1:0]  m_reg, m_next;
    logic [S_W-1:0]     s_reg, s_next;
    logic               neg_reg, neg_next;

    logic [AXIS_W:0]    ext;
    logic [AXIS_W:0]    neg_ext;
    logic [AXIS_W-1:0]  mag;
    logic [S_W-1:0]     sum;
    logic [HUND_W-1:0]  h8;

    // The magnitude of the most negative axis is 0x8000, which still fits.
    assign ext     = {axis[AXIS_W-1], axis};
    assign neg_ext = ~ext + 1'b1;
    assign mag     = axis[AXIS_W-1] ? neg_ext[AXIS_W-1:0] : axis;
    assign sum     = s_reg + (m_reg[0] ? {1'b0, a_reg} : '0);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        m_next    = m_reg;
        s_next    = s_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = A_W'({mag, 6'b0}) + A_W'({mag, 5'b0}) + A_W'({mag, 2'b0});
            m_next    = mag;
            s_next    = '0;
            neg_next  = axis[AXIS_W-1];
        end
        else if (busy_reg)
        begin
            // Right-shift accumulate: s holds the partial product over 2^step.
            s_next   = {1'b0, sum[S_W-1:1]};
            m_next   = {1'b0, m_reg[AXIS_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SQ_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        m_reg   <= m_next;
        s_reg   <= s_next;
        neg_reg <= neg_next;
    end

    // s now holds the product over 2^16; fourteen more bits give over 2^30.
    assign h8         = {1'b0, s_reg[20:14]};
    assign hundredths = neg_reg ? (HUND_W'(0) - h8) : h8;
    assign done       = done_reg;

endmodule

`default_nettype wire

@@ rtl/mwm_div.sv @@
// Restoring radix-2 divider lane: wheel magnitude times 2^16 over the divisor.
// Depends on mwm_pkg and the assertion macro header.
`default_nettype none
`include "mecanum_wheel_mixer_unit_macros.svh"

module mwm_div
    import mwm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [MAG_W-1:0] dividend,
    input  wire logic [MAG_W-1:0] divisor,
    output logic                  done,
    output logic [QUOT_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MAG_W-1:0]   r_reg, r_next;
    logic [MAG_W-1:0]   d_reg, d_next;
    logic [QUOT_W-1:0]  q_reg, q_next;

    logic [MAG_W:0]     trial;
    logic [MAG_W:0]     diff;
    logic               ge;

    // The dividend never exceeds the divisor, so the first step compares it
    // unshifted and produces the integer bit of the fraction.
    assign trial = (cnt_reg == '0) ? {1'b0, r_reg} : {r_reg, 1'b0};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            r_next    = dividend;
            d_next    = divisor;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next   = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            q_next   = {q_reg[QUOT_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        d_reg <= d_next;
        q_reg <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

    `MWM_ASSERT_IMP(a_div_start_idle, clk, rst_n, start, !busy_reg, "divider restarted while busy")

endmodule

`default_nettype wire

@@ rtl/mwm_scale.sv @@
// Bit-serial scaler lane: fraction magnitude times the factor (max_output or unit scale), then the sign.
// Depends on mwm_pkg.
`default_nettype none

module mwm_scale
    import mwm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [QUOT_W-1:0]   mag,
    input  wire logic [MAXOUT_W-1:0] factor,
    input  wire logic                negate,
    output logic                     done,
    output logic signed [CMD_W-1:0]  cmd
);

    localparam int CNT_W = $clog2(SCL_STEPS);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [QUOT_W-1:0]    m_reg, m_next;
    logic [MAXOUT_W-1:0]  f_reg, f_next;
    logic [QUOT_W-1:0]    s_reg, s_next;
    logic [MAXOUT_W-1:0]  lo_reg, lo_next;
    logic                 neg_reg, neg_next;

    logic [QUOT_W:0]      sum;
    logic [CMD_W-1:0]     prod;

    assign sum = {1'b0, s_reg} + (f_reg[0] ? {1'b0, m_reg} : '0);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        m_next    = m_reg;
        f_next    = f_reg;
        s_next    = s_reg;
        lo_next   = lo_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            m_next    = mag;
            f_next    = factor;
            s_next    = '0;
            neg_next  = negate;
        end
        else if (busy_reg)
        begin
            // Low product bits leave the accumulator into lo as they settle.
            s_next   = sum[QUOT_W:1];
            lo_next  = {sum[0], lo_reg[MAXOUT_W-1:1]};
            f_next   = {1'b0, f_reg[MAXOUT_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SCL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        f_reg   <= f_next;
        s_reg   <= s_next;
        lo_reg  <= lo_next;
        neg_reg <= neg_next;
    end

    assign prod = {s_reg, lo_reg};
    assign cmd  = neg_reg ? (CMD_W'(0) - prod) : prod;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ rtl/mecanum_wheel_mixer_unit.sv @@
// Mecanum wheel mixer top level: sequencer, button counter, output register.
// Depends on mwm_pkg, mwm_square, mwm_div, mwm_scale and the macro header.
//
//  Channel      Direction  Content
//  s_axis       in         tdata: three Q1.15 axes; tuser: button and slow flags
//  m_axis       out        tdata: four 27-bit wheel commands; tuser: open_loop
//  max_output   in         write enable and 10-bit data for the scale register
//
// A request is taken only while the sequencer is idle. It then passes through the
// three squarer lanes, the mixing state, the four divider lanes and the four
// scaler lanes, and the done state loads the result into the output register.
// The sequencer then returns to idle, so the next request is taken only after
// the last one has been loaded. The 17-step divider sets the longest phase.
// The output register keeps one finished result while the next request is
// already being processed; a stalled result holds the sequencer only at the final
// load. Reset clears the sequencer, the button counter, the fallback flag and the
// output valid, and sets max_output to 500.
`default_nettype none
`include "mecanum_wheel_mixer_unit_macros.svh"

module mecanum_wheel_mixer_unit
    import mwm_pkg::*;
#(
    parameter int PRESS_LIMIT = 10
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Stick request. tdata from bit 0: strafe_axis[15:0], forward_axis[15:0],
    // rotate_axis[15:0].
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser from bit 0: switch_pressed, slow_mode.
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    // Wheel result. tdata from bit 0: front_left_cmd[26:0], front_right_cmd[26:0],
    // back_left_cmd[26:0], back_right_cmd[26:0], four zero bits.
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser from bit 0: open_loop.
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser,
    // Scale register write.
    input  wire logic                   max_output_we,
    input  wire logic [MAXOUT_W-1:0]    max_output_wdata
);

    localparam logic [PRESS_W-1:0] PRESS_LIMIT_C = PRESS_W'(PRESS_LIMIT);

    state_t                 state_reg, state_next;
    logic [MAXOUT_W-1:0]    max_output_reg;
    logic [PRESS_W-1:0]     press_count_reg, press_count_next;
    logic                   fallback_reg, fallback_next;
    logic                   slow_reg, slow_next;
    logic [NUM_WHEELS-1:0]  wneg_reg, wneg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_TUSER_W-1:0] out_user_reg, out_user_next;

    // Sequencer strobes.
    logic                   accept;
    logic                   sq_start;
    logic                   div_start;
    logic                   scl_start;
    logic                   out_load;

    logic [NUM_AXES-1:0]    sq_done;
    logic [NUM_WHEELS-1:0]  div_done;
    logic [NUM_WHEELS-1:0]  scl_done;
    logic                   sq_all_done;
    logic                   div_all_done;
    logic                   scl_all_done;

    logic signed [AXIS_W-1:0]  axis_in [NUM_AXES];
    logic signed [HUND_W-1:0]  hund    [NUM_AXES];
    logic signed [WHEEL_W-1:0] wheel   [NUM_WHEELS];
    logic [WHEEL_W-1:0]        wabs    [NUM_WHEELS];
    logic [MAG_W-1:0]          wmag    [NUM_WHEELS];
    logic [MAG_W-1:0]          max_mag;
    logic [MAG_W-1:0]          divisor;
    logic [QUOT_W-1:0]         quot    [NUM_WHEELS];
    logic [QUOT_W-1:0]         frac    [NUM_WHEELS];
    logic signed [CMD_W-1:0]   cmd     [NUM_WHEELS];
    logic [MAXOUT_W-1:0]       factor;
    logic [PRESS_W-1:0]        press_inc;

    assign accept = s_axis_tvalid && s_axis_tready;

    assign axis_in[0] = s_axis_tdata[15:0];
    assign axis_in[1] = s_axis_tdata[31:16];
    assign axis_in[2] = s_axis_tdata[47:32];

    assign sq_all_done  = &sq_done;
    assign div_all_done = &div_done;
    assign scl_all_done = &scl_done;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (sq_all_done)
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_all_done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (scl_all_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        sq_start      = 1'b0;
        div_start     = 1'b0;
        scl_start     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                sq_start      = s_axis_tvalid;
            end
            ST_SQUARE:
            begin
            end
            ST_MIX:
            begin
                div_start = 1'b1;
            end
            ST_DIVIDE:
            begin
                scl_start = div_all_done;
            end
            ST_SCALE:
            begin
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Button counter and sticky fallback. Presses need not be consecutive;
    // reaching the limit clears the count and latches fallback for this
    // very request.
    // ------------------------------------------------------------------
    assign press_inc = s_axis_tuser[0] ? (press_count_reg + 1'b1) : press_count_reg;

    always_comb
    begin
        press_count_next = press_count_reg;
        fallback_next    = fallback_reg;
        slow_next        = slow_reg;
        if (accept)
        begin
            slow_next = s_axis_tuser[1];
            if (press_inc >= PRESS_LIMIT_C)
            begin
                press_count_next = '0;
                fallback_next    = 1'b1;
            end
            else
            begin
                press_count_next = press_inc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Squarer lanes: one per axis.
    // ------------------------------------------------------------------
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_square
        mwm_square u_square (
            .clk        (clk),
            .rst_n      (rst_n),
            .start      (sq_start),
            .axis       (axis_in[a]),
            .done       (sq_done[a]),
            .hundredths (hund[a])
        );
    end

    // ------------------------------------------------------------------
    // Mixing: wheel sums in hundredths, their magnitudes and the divisor.
    // The divisor is the largest magnitude when it exceeds one hundred.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [WHEEL_W-1:0] x;
        logic signed [WHEEL_W-1:0] y;
        logic signed [WHEEL_W-1:0] r;
        x = WHEEL_W'(hund[0]);
        y = WHEEL_W'(hund[1]);
        r = WHEEL_W'(hund[2]);
        wheel[0] = x - y + r;
        wheel[1] = -x - y - r;
        wheel[2] = -x - y + r;
        wheel[3] = x - y - r;
        max_mag  = '0;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            wabs[i] = wheel[i][WHEEL_W-1] ? (WHEEL_W'(0) - wheel[i]) : wheel[i];
            wmag[i] = wabs[i][MAG_W-1:0];
            if (wmag[i] > max_mag)
            begin
                max_mag = wmag[i];
            end
        end
        divisor = (max_mag > HUNDRED) ? max_mag : HUNDRED;
    end

    always_comb
    begin
        wneg_next = wneg_reg;
        if (div_start)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                wneg_next[i] = wheel[i][WHEEL_W-1] ^ RIGHT_WHEELS[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider and scaler lanes: one per wheel. Slow mode halves the
    // magnitude, which truncates toward zero once the sign is applied.
    // ------------------------------------------------------------------
    assign factor = fallback_reg ? UNIT_SCALE : max_output_reg;

    for (genvar w = 0; w < NUM_WHEELS; w++)
    begin : g_wheel
        mwm_div u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (wmag[w]),
            .divisor  (divisor),
            .done     (div_done[w]),
            .quotient (quot[w])
        );

        assign frac[w] = slow_reg ? {1'b0, quot[w][QUOT_W-1:1]} : quot[w];

        mwm_scale u_scale (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (scl_start),
            .mag    (frac[w]),
            .factor (factor),
            .negate (wneg_reg[w]),
            .done   (scl_done[w]),
            .cmd    (cmd[w])
        );
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {4'b0, cmd[3], cmd[2], cmd[1], cmd[0]};
            out_user_next  = fallback_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            max_output_reg  <= MAXOUT_RESET;
            press_count_reg <= '0;
            fallback_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            press_count_reg <= press_count_next;
            fallback_reg    <= fallback_next;
            out_valid_reg   <= out_valid_next;
            if (max_output_we)
            begin
                max_output_reg <= max_output_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slow_reg     <= slow_next;
        wneg_reg     <= wneg_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    `MWM_ASSERT_IMP(a_div_done_state, clk, rst_n, div_all_done, state_reg == ST_DIVIDE, "divider finished outside the divide phase")
    `MWM_ASSERT_IMP(a_scl_done_state, clk, rst_n, scl_all_done, state_reg == ST_SCALE, "scaler finished outside the scale phase")
    `MWM_ASSERT_NXT(a_fallback_sticky, clk, rst_n, fallback_reg, fallback_reg, "fallback flag cleared without reset")
    `MWM_ASSERT_IMP(a_press_below_limit, clk, rst_n, 1'b1, press_count_reg < PRESS_LIMIT_C, "button count reached the limit")

endmodule

`default_nettype wire
